### rtl/ppa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppa_pkg;

	// Saturation limits of the result fields
	localparam logic [18:0] PERIM_MAX = 19'h7FFFF;
	localparam logic [24:0] AREA_MAX  = 25'd16777216;

	typedef enum logic [1:0] {
		KIND_SEG,
		KIND_TRI,
		KIND_QUAD
	} kind_t;

	// Control that travels down the pipeline beside the lanes
	typedef struct packed {
		logic  vld;
		kind_t kind;
	} ppa_ctl_t;

	// Fewer than three corners is a segment, three a triangle, four or more a quadrilateral
	function automatic kind_t decode_kind(input logic [2:0] n);
		kind_t k;
		if (n < 3'd3) begin
			k = KIND_SEG;
		end else if (n == 3'd3) begin
			k = KIND_TRI;
		end else begin
			k = KIND_QUAD;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

### rtl/ppa_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One side length: difference, squares, sum, one root bit per stage, round.
module ppa_lane import ppa_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          ce,
	input  wire logic signed [COORD_WIDTH-1:0] from_x,
	input  wire logic signed [COORD_WIDTH-1:0] from_y,
	input  wire logic signed [COORD_WIDTH-1:0] to_x,
	input  wire logic signed [COORD_WIDTH-1:0] to_y,
	output logic             [COORD_WIDTH+1:0] len
);

	localparam int W  = COORD_WIDTH;
	localparam int RW = W + 1;
	localparam int SW = 2 * RW;

	logic signed [W:0]   dx, dy;
	logic [W-1:0]        mx_s1, my_s1;
	logic [2*W-1:0]      sqx_s2, sqy_s2;
	logic [SW-1:0]       rad_s  [RW+1];
	logic [RW:0]         rem_s  [RW+1];
	logic [RW-1:0]       root_s [RW+1];
	logic [RW:0]         len_q;

	always_comb begin
		dx = (W+1)'(to_x) - (W+1)'(from_x);
		dy = (W+1)'(to_y) - (W+1)'(from_y);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mx_s1     <= dx[W] ? W'(-dx) : dx[W-1:0];
			my_s1     <= dy[W] ? W'(-dy) : dy[W-1:0];
			sqx_s2    <= mx_s1 * mx_s1;
			sqy_s2    <= my_s1 * my_s1;
			rad_s[0]  <= SW'(sqx_s2) + SW'(sqy_s2);
		end
	end

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_root
		logic [RW+2:0] cur, trial;
		logic          ge;

		always_comb begin
			cur   = {rem_s[k], rad_s[k][SW-1-2*k -: 2]};
			trial = (RW+3)'({root_s[k], 2'b01});
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rad_s[k+1]  <= rad_s[k];
				rem_s[k+1]  <= ge ? (RW+1)'(cur - trial) : cur[RW:0];
				root_s[k+1] <= (RW)'({root_s[k], ge});
			end
		end
	end

	// round to nearest: bump when the remainder exceeds the root
	always_ff @(posedge clk) begin
		if (ce) begin
			len_q <= {1'b0, root_s[RW]} + (RW+1)'(rem_s[RW] > {1'b0, root_s[RW]});
		end
	end

	assign len = len_q;

endmodule

`default_nettype wire

### rtl/ppa_cross.sv
`timescale 1ns / 1ps
`default_nettype none

// Area lane: cross product magnitude, halved and rounded, then delayed.
module ppa_cross import ppa_pkg::*; #(
	parameter int COORD_WIDTH   = 16,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          ce,
	input  wire logic signed [COORD_WIDTH-1:0] u_from_x,
	input  wire logic signed [COORD_WIDTH-1:0] u_from_y,
	input  wire logic signed [COORD_WIDTH-1:0] u_to_x,
	input  wire logic signed [COORD_WIDTH-1:0] u_to_y,
	input  wire logic signed [COORD_WIDTH-1:0] v_from_x,
	input  wire logic signed [COORD_WIDTH-1:0] v_from_y,
	input  wire logic signed [COORD_WIDTH-1:0] v_to_x,
	input  wire logic signed [COORD_WIDTH-1:0] v_to_y,
	output logic             [24:0]            area
);

	localparam int W   = COORD_WIDTH;
	localparam int F   = FRACTION_BITS;
	localparam int DW  = 2 * W + 3;
	localparam int XW  = DW + 1;
	localparam int CW  = (XW > 26) ? XW : 26;
	localparam int DLY = W + 1;
	localparam logic [XW-1:0] HALF = XW'(1) << F;

	logic signed [W:0]     ux_s1, uy_s1, vx_s1, vy_s1;
	logic signed [2*W+1:0] p1_s2, p2_s2;
	logic signed [DW-1:0]  d_s3;
	logic [DW-1:0]         mag;
	logic [XW-1:0]         x;
	logic [CW-1:0]         sh;
	logic [24:0]           area_s4;
	logic [24:0]           ar_s [DLY];

	always_comb begin
		mag = d_s3[DW-1] ? DW'(-d_s3) : DW'(d_s3);
		x   = XW'(mag) + HALF;
		sh  = CW'(x) >> (F + 1);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ux_s1   <= (W+1)'(u_to_x) - (W+1)'(u_from_x);
			uy_s1   <= (W+1)'(u_to_y) - (W+1)'(u_from_y);
			vx_s1   <= (W+1)'(v_to_x) - (W+1)'(v_from_x);
			vy_s1   <= (W+1)'(v_to_y) - (W+1)'(v_from_y);
			p1_s2   <= ux_s1 * vy_s1;
			p2_s2   <= uy_s1 * vx_s1;
			d_s3    <= DW'(p1_s2) - DW'(p2_s2);
			area_s4 <= (sh > CW'(AREA_MAX)) ? AREA_MAX : sh[24:0];
			ar_s[0] <= area_s4;
			for (int i = 1; i < DLY; i++) begin
				ar_s[i] <= ar_s[i-1];
			end
		end
	end

	assign area = ar_s[DLY-1];

endmodule

`default_nettype wire

### rtl/ppa_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Add the side lengths the shape uses, saturate, hold the result beat.
module ppa_merge import ppa_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   ce,
	input  wire ppa_ctl_t               ctl,
	input  wire logic [COORD_WIDTH+1:0] len0,
	input  wire logic [COORD_WIDTH+1:0] len1,
	input  wire logic [COORD_WIDTH+1:0] len2,
	input  wire logic [COORD_WIDTH+1:0] len3,
	input  wire logic [24:0]            area_in,
	output logic                        out_valid,
	output logic [18:0]                 perimeter,
	output logic [24:0]                 area,
	output logic                        area_ok
);

	localparam int PW  = COORD_WIDTH + 4;
	localparam int CPW = (PW > 20) ? PW : 20;

	logic [PW-1:0] sum;
	logic          vld_q;
	logic [18:0]   perim_q;
	logic [24:0]   area_q;
	logic          ok_q;

	always_comb begin
		sum = PW'(len0);
		if (ctl.kind != KIND_SEG) begin
			sum = sum + PW'(len1) + PW'(len3);
		end
		if (ctl.kind == KIND_QUAD) begin
			sum = sum + PW'(len2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ce) begin
			vld_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			perim_q <= (CPW'(sum) > CPW'(PERIM_MAX)) ? PERIM_MAX : sum[18:0];
			area_q  <= (ctl.kind == KIND_SEG) ? '0 : area_in;
			ok_q    <= (ctl.kind != KIND_SEG);
		end
	end

	assign out_valid = vld_q;
	assign perimeter = perim_q;
	assign area      = area_q;
	assign area_ok   = ok_q;

endmodule

`default_nettype wire

### rtl/polygon_perimeter_and_area.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload
// s_axis   | in  | tdata: point_a_x, point_a_y, point_b_x, point_b_y, point_c_x,
//          |     |        point_c_y, point_d_x, point_d_y, corner_count
// m_axis   | out | tdata: perimeter_len, shape_area; tuser: area_valid
//
// One beat in per clock while the output is not stalled, one result beat out
// per input beat, in order. Each beat passes the difference, square and sum
// registers, the square root stages with one root bit per stage, a rounding
// register and the output register.
// arst_n clears only the valid bits; the datapath registers have no reset.
// A stalled output beat freezes the whole pipeline; s_axis_tready is low
// only while the output holds a beat that is not being taken.
module polygon_perimeter_and_area import ppa_pkg::*; #(
	parameter int COORD_WIDTH   = 16,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y,
	// point_d_x, point_d_y (COORD_WIDTH each), corner_count (3), zero pad
	input  wire logic [((8*COORD_WIDTH+3+7)/8)*8-1:0] s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// perimeter_len [18:0], shape_area [43:19], zero pad [47:44]
	output logic [47:0]                m_axis_tdata,
	// area_valid
	output logic                       m_axis_tuser
);

	localparam int W   = COORD_WIDTH;
	localparam int LAT = W + 5;

	logic signed [W-1:0] px [4];
	logic signed [W-1:0] py [4];
	logic [2:0]          corners;
	kind_t               kind_in;
	logic                ce;
	logic                vld_s  [LAT];
	kind_t               kind_s [LAT];
	ppa_ctl_t            ctl_out;
	logic [W+1:0]        len [4];
	logic [24:0]         area_lane;
	logic [18:0]         perim;
	logic [24:0]         area;
	logic                area_ok;

	// unpack corners A to D
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			px[i] = s_axis_tdata[(2*i)*W +: W];
			py[i] = s_axis_tdata[(2*i+1)*W +: W];
		end
		corners = s_axis_tdata[8*W +: 3];
		kind_in = decode_kind(corners);
	end

	// advance everything unless the output beat is held
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (ce) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			kind_s[0] <= kind_in;
			for (int i = 1; i < LAT; i++) begin
				kind_s[i] <= kind_s[i-1];
			end
		end
	end

	assign ctl_out = '{vld: vld_s[LAT-1], kind: kind_s[LAT-1]};

	// sides AB, BC, CD and the closing side back to A (from C or D)
	ppa_lane #(.COORD_WIDTH(W)) u_lane_ab (
		.clk(clk), .ce(ce),
		.from_x(px[0]), .from_y(py[0]), .to_x(px[1]), .to_y(py[1]),
		.len(len[0])
	);

	ppa_lane #(.COORD_WIDTH(W)) u_lane_bc (
		.clk(clk), .ce(ce),
		.from_x(px[1]), .from_y(py[1]), .to_x(px[2]), .to_y(py[2]),
		.len(len[1])
	);

	ppa_lane #(.COORD_WIDTH(W)) u_lane_cd (
		.clk(clk), .ce(ce),
		.from_x(px[2]), .from_y(py[2]), .to_x(px[3]), .to_y(py[3]),
		.len(len[2])
	);

	ppa_lane #(.COORD_WIDTH(W)) u_lane_close (
		.clk(clk), .ce(ce),
		.from_x((kind_in == KIND_QUAD) ? px[3] : px[2]),
		.from_y((kind_in == KIND_QUAD) ? py[3] : py[2]),
		.to_x(px[0]), .to_y(py[0]),
		.len(len[3])
	);

	// triangle: AB x AC; quadrilateral: diagonals AC x BD
	ppa_cross #(.COORD_WIDTH(W), .FRACTION_BITS(FRACTION_BITS)) u_cross (
		.clk(clk), .ce(ce),
		.u_from_x(px[0]), .u_from_y(py[0]),
		.u_to_x((kind_in == KIND_QUAD) ? px[2] : px[1]),
		.u_to_y((kind_in == KIND_QUAD) ? py[2] : py[1]),
		.v_from_x((kind_in == KIND_QUAD) ? px[1] : px[0]),
		.v_from_y((kind_in == KIND_QUAD) ? py[1] : py[0]),
		.v_to_x((kind_in == KIND_QUAD) ? px[3] : px[2]),
		.v_to_y((kind_in == KIND_QUAD) ? py[3] : py[2]),
		.area(area_lane)
	);

	ppa_merge #(.COORD_WIDTH(W)) u_merge (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.ctl(ctl_out),
		.len0(len[0]), .len1(len[1]), .len2(len[2]), .len3(len[3]),
		.area_in(area_lane),
		.out_valid(m_axis_tvalid),
		.perimeter(perim), .area(area), .area_ok(area_ok)
	);

	assign m_axis_tdata = {4'b0000, area, perim};
	assign m_axis_tuser = area_ok;

endmodule

`default_nettype wire

### rtl/ppa_check.sv
`timescale 1ns / 1ps
`default_nettype none

module ppa_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	// hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result beat changed");

	// no area without a shape
	a_seg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[43:19] == 25'd0)
		else $error("area reported for a segment");

	a_area_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[43:19] <= 25'd16777216)
		else $error("area beyond saturation limit");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[47:44] == 4'd0)
		else $error("pad bits set");

	// an empty output never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind polygon_perimeter_and_area ppa_check u_ppa_check (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

`default_nettype wire
